// ===== sv/rtba_pkg.sv =====
package rtba_pkg;

  localparam int MaxRegionsDef = 64;
  localparam int PageBytesDef  = 4096;

  localparam int CfgIdxW = 2;

  // Operation codes.
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_CHECK   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_REFUSED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POOL_SIZE = 2'd1;

  localparam logic [31:0] PoolSizeReset = 32'd4194304;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] region_start;
    logic        legitimate;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

endpackage

// ===== sv/rtba_ram.sv =====
module rtba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/region_table_bump_allocator_top.sv =====
// Region allocator with a bump pointer. Each beat on the input channel is one
// operation (allocate, release or check) and yields exactly one result beat.
// The region table (start, length) lives in a single-port-read RAM; allocate
// writes an entry starting at the bump pointer into the next slot and passes
// through S_ALLOC and S_DONE to the result register. Release and check walk the
// table one entry per cycle through the RAM read port; a release hit then
// passes through S_REL_RD and S_REL_WR to move the last entry into the hole.
// One operation is in flight at a time, but a new one is accepted
// while the previous result still waits in the output register. The table
// needs no clearing after reset; writing pool_base restarts the pool at once.
module region_table_bump_allocator_top import rtba_pkg::*; #(
  parameter int MAX_REGIONS = MaxRegionsDef,
  parameter int PAGE_BYTES  = PageBytesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  req_t               in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsp_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CntW = $clog2(MAX_REGIONS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REGIONS);
  localparam logic [31:0] Page = 32'(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_REL_RD,
    S_REL_WR,
    S_DONE
  } state_t;

  state_t         state;
  req_t           req;
  logic [31:0]    pool_size;
  logic [CntW-1:0] count;
  logic [31:0]    bytes_in_use;
  logic [31:0]    next_free;
  logic [CntW-1:0] issue_idx;
  logic           rvalid;
  logic [IdxW-1:0] ridx;
  logic [IdxW-1:0] hit_idx;
  entry_t         hit_entry;
  rsp_t           rsp;

  logic           cfg_we;
  logic [33:0]    need;
  logic           refuse;
  entry_t         rd_entry;
  entry_t         wr_entry;
  logic [32:0]    upper;
  logic           chk_hit;
  logic           rel_hit;
  logic           match;
  logic           issue_more;
  logic [CntW-1:0] last_idx;
  logic           ram_rd_en;
  logic [IdxW-1:0] ram_rd_addr;
  logic           ram_wr_en;
  logic [IdxW-1:0] ram_wr_addr;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);

  // Capacity is tested without wrap; the reserved page counts against the pool.
  assign need   = {2'b00, bytes_in_use} + {2'b00, req.request_size} + {2'b00, Page};
  assign refuse = (need > {2'b00, pool_size}) || (count >= CntMax);

  assign upper      = {1'b0, rd_entry.start} + {1'b0, rd_entry.length};
  assign chk_hit    = (req.address >= rd_entry.start) && ({1'b0, req.address} < upper);
  assign rel_hit    = (rd_entry.start == req.address);
  assign match      = rvalid && ((req.func == FUNC_RELEASE) ? rel_hit : chk_hit);
  assign issue_more = (issue_idx < count);
  assign last_idx   = count - 1'b1;

  always_comb begin
    ram_rd_en   = ((state == S_SCAN) && issue_more) || (state == S_REL_RD);
    ram_rd_addr = (state == S_REL_RD) ? last_idx[IdxW-1:0] : issue_idx[IdxW-1:0];
    ram_wr_en   = ((state == S_ALLOC) && !refuse) || (state == S_REL_WR);
    ram_wr_addr = (state == S_ALLOC) ? count[IdxW-1:0] : hit_idx;
    if (state == S_ALLOC) begin
      wr_entry.start  = next_free;
      wr_entry.length = req.request_size;
    end else begin
      wr_entry = rd_entry;
    end
  end

  rtba_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_REGIONS)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(wr_entry),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pool_size    <= PoolSizeReset;
      count        <= '0;
      bytes_in_use <= '0;
      next_free    <= Page;
      issue_idx    <= '0;
      rvalid       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            case (in_data.func) inside
              FUNC_ALLOC: begin
                state <= S_ALLOC;
              end
              FUNC_RELEASE, FUNC_CHECK: begin
                issue_idx <= '0;
                rvalid    <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
                rsp   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end

        S_ALLOC: begin
          if (refuse) begin
            rsp.status       <= STATUS_REFUSED;
            rsp.region_start <= '0;
          end else begin
            rsp.status       <= STATUS_OK;
            rsp.region_start <= next_free;
            count            <= count + 1'b1;
            bytes_in_use     <= bytes_in_use + req.request_size;
            next_free        <= next_free + req.request_size;
          end
          rsp.legitimate <= 1'b0;
          state          <= S_DONE;
        end

        // Reads are issued back to back; the compare sees each entry in the
        // cycle after its address went out.
        S_SCAN: begin
          rvalid <= issue_more && !match;
          ridx   <= issue_idx[IdxW-1:0];
          if (issue_more) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (match) begin
            if (req.func == FUNC_RELEASE) begin
              hit_idx   <= ridx;
              hit_entry <= rd_entry;
              state     <= S_REL_RD;
            end else begin
              rsp.status       <= STATUS_OK;
              rsp.region_start <= '0;
              rsp.legitimate   <= 1'b1;
              state            <= S_DONE;
            end
          end else if (!rvalid && !issue_more) begin
            rsp.status       <= (req.func == FUNC_RELEASE) ? STATUS_NOT_FOUND : STATUS_OK;
            rsp.region_start <= '0;
            rsp.legitimate   <= 1'b0;
            state            <= S_DONE;
          end
        end

        S_REL_RD: begin
          state <= S_REL_WR;
        end

        // The last entry, just read, is written into the hole.
        S_REL_WR: begin
          count        <= count - 1'b1;
          bytes_in_use <= bytes_in_use - hit_entry.length;
          if ((hit_entry.start + hit_entry.length) == next_free) begin
            next_free <= hit_entry.start;
          end
          rsp   <= '0;
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= rsp;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_BASE: begin
            count        <= '0;
            bytes_in_use <= '0;
            next_free    <= cfg_data + Page;
          end
          CFG_POOL_SIZE: begin
            pool_size <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The region count moves by at most one per cycle outside configuration.
  assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> (count == $past(count)) || (count == $past(count) + 1'b1) ||
                (count == $past(count) - 1'b1))
    else $error("region count jumped");

  // Completing a release drops one entry and its bytes.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REL_WR) && !cfg_we |=>
      (count == $past(count) - 1'b1) &&
      (bytes_in_use == $past(bytes_in_use) - $past(hit_entry.length)))
    else $error("release bookkeeping wrong");

  // A result is not loaded over one that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_valid && out_stall |=> (state == S_DONE))
    else $error("result overwrote a stalled beat");

endmodule

// ===== verif/region_table_bump_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module region_table_bump_allocator_top_tb import rtba_pkg::*;;

  localparam int CycleLimit = 2500000;
  localparam int ItemsPerPhase = 190;
  localparam int PhaseCount = 10;
  // Function code that the block treats as a no-op.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  class region_book;
    logic [31:0] base_reg;
    logic [31:0] size_reg;
    logic [31:0] starts [MaxRegionsDef];
    logic [31:0] lengths [MaxRegionsDef];
    logic [6:0]  count;
    logic [31:0] used;
    logic [31:0] bump;
    rsp_t        owed[$];
    int          errors;
    int          n_ops;
    int          n_writes;
    int          n_refused;
    int          n_full;
    int          n_missed;
    int          n_hits;

    function new();
      base_reg = '0;
      size_reg = PoolSizeReset;
      errors = 0;
      n_ops = 0;
      n_writes = 0;
      n_refused = 0;
      n_full = 0;
      n_missed = 0;
      n_hits = 0;
      restart();
    endfunction

    function void restart();
      count = '0;
      used = '0;
      bump = base_reg + 32'(PageBytesDef);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      n_writes++;
      if (idx == CFG_POOL_BASE) begin
        base_reg = val;
        restart();
      end else if (idx == CFG_POOL_SIZE) begin
        size_reg = val;
      end
    endfunction

    // Applies one operation to the table and returns the result it must give.
    function rsp_t run_op(req_t r);
      rsp_t        res;
      logic [63:0] need;
      logic [32:0] upper;
      logic [31:0] len;
      logic [31:0] top_end;
      int          hit;
      res = '0;
      case (r.func)
        FUNC_ALLOC: begin
          need = 64'(used) + 64'(r.request_size) + 64'(PageBytesDef);
          if (need > 64'(size_reg) || count >= MaxRegionsDef) begin
            res.status = STATUS_REFUSED;
          end else begin
            res.region_start = bump;
            starts[count] = bump;
            lengths[count] = r.request_size;
            count++;
            used = used + r.request_size;
            bump = bump + r.request_size;
          end
        end
        FUNC_RELEASE: begin
          hit = -1;
          for (int i = 0; i < count; i++) begin
            if (hit < 0 && starts[i] == r.address) hit = i;
          end
          if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            len = lengths[hit];
            count--;
            used = used - len;
            top_end = starts[hit] + len;
            if (top_end == bump) bump = starts[hit];
            starts[hit] = starts[count];
            lengths[hit] = lengths[count];
          end
        end
        FUNC_CHECK: begin
          for (int i = 0; i < count; i++) begin
            upper = {1'b0, starts[i]} + {1'b0, lengths[i]};
            if ({1'b0, r.address} >= {1'b0, starts[i]} && {1'b0, r.address} < upper)
              res.legitimate = 1'b1;
          end
        end
        default: begin
        end
      endcase
      return res;
    endfunction

    function void log_request(req_t r);
      rsp_t res;
      if (r.func == FUNC_ALLOC && count >= MaxRegionsDef) n_full++;
      res = run_op(r);
      owed.push_back(res);
      n_ops++;
      if (res.status == STATUS_REFUSED) n_refused++;
      if (res.status == STATUS_NOT_FOUND) n_missed++;
      if (res.legitimate) n_hits++;
    endfunction

    function void match_result(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        $error("result beat with nothing pending: status %0d start %h legitimate %0d",
               got.status, got.region_start, got.legitimate);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.region_start !== want.region_start) begin
        $error("region_start mismatch: expected %h, actual %h",
               want.region_start, got.region_start);
        errors++;
      end
      if (got.legitimate !== want.legitimate) begin
        $error("legitimate mismatch: expected %0d, actual %0d",
               want.legitimate, got.legitimate);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid;
  logic               in_stall;
  req_t               in_data;
  logic               out_valid;
  logic               out_stall;
  rsp_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  region_book book;
  int         cycle_count = 0;
  bit         steady_in = 1'b0;
  bit         steady_out = 1'b0;

  region_table_bump_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, book.owed.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) book.match_result(out_data);
      if (in_valid && !in_stall) book.log_request(in_data);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    int unsigned left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left != 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        left = steady_out ? 0 : idle_len();
      end
    end
  end

  function automatic req_t mk_op(logic [1:0] func, logic [31:0] size, logic [31:0] addr);
    req_t r;
    r.func = func;
    r.request_size = size;
    r.address = addr;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  // when the next beat follows without a gap.
  task automatic send(req_t r);
    int unsigned gap;
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    gap = steady_in ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (book.owed.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic req_t make_op(int kind);
    req_t        r;
    int unsigned roll;
    int unsigned aw;
    int unsigned rw;
    int unsigned cw;
    int unsigned k;
    logic [31:0] s;
    logic [31:0] l;
    logic [63:0] room;
    case (kind)
      0: begin aw = 40; rw = 30; cw = 25; end
      1: begin aw = 70; rw = 10; cw = 17; end
      2: begin aw = 35; rw = 45; cw = 17; end
      default: begin aw = 30; rw = 20; cw = 45; end
    endcase
    r.request_size = $urandom();
    r.address = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < aw) begin
      r.func = FUNC_ALLOC;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        r.request_size = '0;
      end else if (roll < 70) begin
        r.request_size = $urandom_range(1, 'h400);
      end else if (roll < 88) begin
        r.request_size = $urandom_range(1, 'h3000);
      end else if (roll < 95) begin
        // Exactly the space left, or one byte more.
        room = 64'(book.size_reg) - 64'(PageBytesDef) - 64'(book.used);
        if (64'(book.size_reg) < 64'(PageBytesDef) + 64'(book.used)) room = '0;
        r.request_size = room[31:0] + 32'($urandom_range(0, 1));
      end
    end else if (roll < aw + rw) begin
      r.func = FUNC_RELEASE;
      roll = $urandom_range(0, 99);
      if (book.count != 0 && roll < 70) begin
        r.address = book.starts[$urandom_range(0, book.count - 1)];
      end else if (book.count != 0 && roll < 80) begin
        r.address = book.starts[book.count - 1];
      end else if (roll < 90) begin
        r.address = book.bump;
      end
    end else if (roll < aw + rw + cw) begin
      r.func = FUNC_CHECK;
      if (book.count != 0 && $urandom_range(0, 99) < 75) begin
        k = $urandom_range(0, book.count - 1);
        s = book.starts[k];
        l = book.lengths[k];
        case ($urandom_range(0, 4))
          0: r.address = s;
          1: r.address = s + l - 32'd1;
          2: r.address = s + l;
          3: r.address = s - 32'd1;
          default: r.address = s + ((l == '0) ? '0 : ($urandom() % l));
        endcase
      end
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  initial begin
    logic [31:0] base_pick;
    logic [31:0] size_pick;
    book = new();
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values first: empty table, default pool.
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0));
    send(mk_op(FUNC_RELEASE, 32'h0, 32'h0000_1000));
    send(mk_op(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk_op(FUNC_ALLOC, 32'h0, 32'h0));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0000_1000));
    send(mk_op(FUNC_ALLOC, 32'h100, 32'h0));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0000_1000));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0000_10FF));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0000_1100));
    send(mk_op(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0));
    send(mk_op(FUNC_ALLOC, PoolSizeReset - 32'(PageBytesDef) - 32'h100, 32'h0));
    // The pool is now exactly full: a zero-byte region still fits, one byte does not.
    send(mk_op(FUNC_ALLOC, 32'h0, 32'h0));
    send(mk_op(FUNC_ALLOC, 32'h1, 32'h0));
    // Two regions start at the same address; the lower table slot goes first.
    send(mk_op(FUNC_RELEASE, 32'h0, 32'h0000_1000));
    send(mk_op(FUNC_RELEASE, 32'h0, 32'h0001_2345));
    idle_input();
    wait_idle();

    write_reg(CFG_SPARE_A, $urandom());
    write_reg(CFG_SPARE_B, $urandom());
    write_reg(CFG_POOL_SIZE, 32'h0);
    send(mk_op(FUNC_ALLOC, 32'h0, 32'h0));
    idle_input();
    wait_idle();

    // Pool near the top of the address space so the bump pointer wraps.
    write_reg(CFG_POOL_BASE, 32'hFFFF_E000);
    write_reg(CFG_POOL_SIZE, 32'hFFFF_FFFF);
    send(mk_op(FUNC_ALLOC, 32'h2000, 32'h0));
    send(mk_op(FUNC_CHECK, 32'h0, 32'hFFFF_FFFF));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0));
    send(mk_op(FUNC_ALLOC, 32'h10, 32'h0));
    send(mk_op(FUNC_RELEASE, 32'h0, 32'hFFFF_F000));
    send(mk_op(FUNC_RELEASE, 32'h0, 32'h0000_1000));
    send(mk_op(FUNC_ALLOC, 32'h4, 32'h0));
    send(mk_op(FUNC_CHECK, 32'h0, 32'h0000_1003));
    send(mk_op(FUNC_RELEASE, 32'h0, 32'hFFFF_F000));

    for (int p = 0; p < PhaseCount; p++) begin
      idle_input();
      wait_idle();
      case (p)
        0: begin base_pick = 32'h0; size_pick = 32'hFFFF_FFFF; end
        1: begin base_pick = 32'hFFFF_FFFF; size_pick = 32'h0002_0000; end
        2: begin base_pick = 32'hFFFF_C000; size_pick = 32'h0000_8000; end
        3: begin base_pick = $urandom(); size_pick = PoolSizeReset; end
        default: begin
          case ($urandom_range(0, 3))
            0: base_pick = 32'h0;
            1: base_pick = $urandom() & 32'hFFFF_F000;
            2: base_pick = 32'hFFFF_FFFF - $urandom_range(0, 'h10000);
            default: base_pick = $urandom();
          endcase
          case ($urandom_range(0, 7))
            0: size_pick = 32'(PageBytesDef) - 32'd1;
            1: size_pick = 32'(PageBytesDef);
            2: size_pick = $urandom_range('h2000, 'h40000);
            3: size_pick = PoolSizeReset;
            4: size_pick = 32'hFFFF_FFFF;
            5: size_pick = $urandom_range('h1000, 'h20000);
            default: size_pick = $urandom();
          endcase
        end
      endcase
      write_reg(CFG_POOL_SIZE, size_pick);
      // Now and then keep the table from the last phase.
      if (p < 4 || $urandom_range(0, 3) != 0) write_reg(CFG_POOL_BASE, base_pick);

      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k % 48 == 0) begin
          steady_in = ($urandom_range(0, 4) == 0);
          steady_out = ($urandom_range(0, 4) == 0);
        end
        if ($urandom_range(0, 149) == 0) begin
          idle_input();
          wait_idle();
        end
        send(make_op(p % 4));
      end
    end

    idle_input();
    wait_idle();
    repeat (MaxRegionsDef + 16) @(negedge clk);
    if (book.owed.size() != 0) begin
      $error("%0d expected results never arrived", book.owed.size());
      book.errors++;
    end
    $display("Checked %0d operations under %0d register writes; %0d allocates refused",
             book.n_ops, book.n_writes, book.n_refused);
    $display("(%0d with the table full), %0d release misses, %0d check hits.",
             book.n_full, book.n_missed, book.n_hits);
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rtba_pkg.sv
sv/rtba_ram.sv
sv/region_table_bump_allocator_top.sv
verif/region_table_bump_allocator_top_tb.sv
